FILE: hw/rtl/xlg_pkg.sv
`default_nettype none

package xlg_pkg;

    localparam int TOP_TAP_DEFAULT      = 133;
    localparam int WARMUP_TICKS_DEFAULT = 1024;

    localparam int SEED_W  = 64;
    localparam int WORD_W  = 32;
    localparam int TAP_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_THIRD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_FOURTH = 2'd2;

    localparam logic [TAP_W-1:0] TAP_SECOND_RESET = 8'd9;
    localparam logic [TAP_W-1:0] TAP_THIRD_RESET  = 8'd8;
    localparam logic [TAP_W-1:0] TAP_FOURTH_RESET = 8'd2;

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

    typedef struct packed {
        logic [TAP_W-1:0] tap_second;
        logic [TAP_W-1:0] tap_third;
        logic [TAP_W-1:0] tap_fourth;
    } taps_t;

endpackage

`default_nettype wire

FILE: hw/rtl/xlg_cell.sv
`default_nettype none

module xlg_cell (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  wire logic shift,
    input  wire logic load_bit,
    input  wire logic shift_in,
    output logic      q
);

    logic q_reg;
    logic q_next;

    always_comb begin
        q_next = q_reg;
        if (load) begin
            q_next = load_bit;
        end else if (shift) begin
            q_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= 1'b0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/xlg_chain.sv
`default_nettype none

module xlg_chain #(
    parameter int TOP_TAP = xlg_pkg::TOP_TAP_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire xlg_pkg::chain_ctrl_t        ctrl,
    input  wire logic [xlg_pkg::SEED_W-1:0]  seed,
    input  wire xlg_pkg::taps_t              taps,
    output logic                             out_bit
);

    localparam int SEL_DEPTH = 2 ** xlg_pkg::TAP_W;

    logic [TOP_TAP:0]     cells;
    logic [TOP_TAP:0]     shift_in;
    logic [TOP_TAP:0]     load_bits;
    logic [SEL_DEPTH-1:0] padded;
    logic                 feedback;

    for (genvar i = 0; i <= TOP_TAP; i++) begin : g_cell
        if (i < xlg_pkg::SEED_W && i < TOP_TAP) begin : g_seed
            assign load_bits[i] = seed[i];
        end else begin : g_zero
            assign load_bits[i] = 1'b0;
        end

        if (i == TOP_TAP) begin : g_top
            assign shift_in[i] = feedback;
        end else begin : g_mid
            assign shift_in[i] = cells[i+1];
        end

        xlg_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load     (ctrl.load),
            .shift    (ctrl.shift),
            .load_bit (load_bits[i]),
            .shift_in (shift_in[i]),
            .q        (cells[i])
        );
    end

    // Tap positions past the top cell read as zero.
    for (genvar j = 0; j < SEL_DEPTH; j++) begin : g_pad
        if (j <= TOP_TAP) begin : g_live
            assign padded[j] = cells[j];
        end else begin : g_dead
            assign padded[j] = 1'b0;
        end
    end

    assign feedback = 1'b1 ^ cells[TOP_TAP] ^ padded[taps.tap_second]
                    ^ padded[taps.tap_third] ^ padded[taps.tap_fourth];

    assign out_bit = cells[0];

endmodule

`default_nettype wire

FILE: hw/rtl/xnor_lfsr_word_generator.sv
`default_nettype none

// Channel  Handshake          Payload
// s_       s_valid / s_ready  s_op, s_seed_value
// m_       m_valid / m_ready  m_random_word
// cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A next beat shifts the cell chain one register per cycle, save for the stall below.
// A seed beat loads in its accept cycle and then runs its warm-up shifts, as set by WARMUP_TICKS.
// A new beat is taken on the edge that ends the current one, so next beats run
// back to back. Reset is synchronous and clears the chain to all zeros.
// The chain stops on its final shift while a finished word waits in m_.

module xnor_lfsr_word_generator #(
    parameter int TOP_TAP      = xlg_pkg::TOP_TAP_DEFAULT,
    parameter int WARMUP_TICKS = xlg_pkg::WARMUP_TICKS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_op,
    input  wire logic [xlg_pkg::SEED_W-1:0]      s_seed_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [xlg_pkg::WORD_W-1:0]           m_random_word,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [xlg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [xlg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_MAX = (WARMUP_TICKS > xlg_pkg::WORD_W) ? WARMUP_TICKS
                                                              : xlg_pkg::WORD_W;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    xlg_pkg::taps_t        taps_reg;
    xlg_pkg::chain_ctrl_t  ctrl;
    logic                  busy_reg;
    logic                  op_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [xlg_pkg::WORD_W-1:0] acc_reg;
    logic [xlg_pkg::WORD_W-1:0] word_reg;
    logic                  m_valid_reg;
    logic                  out_bit;
    logic                  last;
    logic                  tick_fire;
    logic                  s_fire;

    assign last      = (cnt_reg == CNT_W'(1));
    assign tick_fire = busy_reg
                     && !(last && op_reg == xlg_pkg::OP_NEXT && m_valid_reg && !m_ready);
    assign s_ready   = !busy_reg || (tick_fire && last);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign ctrl.load  = s_fire && (s_op == xlg_pkg::OP_SEED);
    assign ctrl.shift = tick_fire;

    xlg_chain #(
        .TOP_TAP (TOP_TAP)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .seed    (s_seed_value),
        .taps    (taps_reg),
        .out_bit (out_bit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg.tap_second <= xlg_pkg::TAP_SECOND_RESET;
            taps_reg.tap_third  <= xlg_pkg::TAP_THIRD_RESET;
            taps_reg.tap_fourth <= xlg_pkg::TAP_FOURTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                xlg_pkg::CFG_TAP_SECOND: taps_reg.tap_second <= cfg_data;
                xlg_pkg::CFG_TAP_THIRD:  taps_reg.tap_third  <= cfg_data;
                xlg_pkg::CFG_TAP_FOURTH: taps_reg.tap_fourth <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            op_reg   <= xlg_pkg::OP_SEED;
            cnt_reg  <= '0;
        end else if (s_fire) begin
            op_reg <= s_op;
            if (s_op == xlg_pkg::OP_SEED) begin
                cnt_reg  <= CNT_W'(WARMUP_TICKS);
                busy_reg <= (WARMUP_TICKS != 0);
            end else begin
                cnt_reg  <= CNT_W'(xlg_pkg::WORD_W);
                busy_reg <= 1'b1;
            end
        end else if (tick_fire) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            acc_reg <= {out_bit, acc_reg[xlg_pkg::WORD_W-1:1]};
        end
        if (tick_fire && last && op_reg == xlg_pkg::OP_NEXT) begin
            word_reg <= {out_bit, acc_reg[xlg_pkg::WORD_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick_fire && last && op_reg == xlg_pkg::OP_NEXT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = word_reg;

`ifndef SYNTHESIS
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg == (cnt_reg != '0))
        else $error("busy flag and tick count disagree");

    a_no_accept_midway: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !last) |-> !s_ready)
        else $error("input taken while a beat is still running");

    a_next_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_op == xlg_pkg::OP_NEXT) |=> (busy_reg && cnt_reg == CNT_W'(xlg_pkg::WORD_W)))
        else $error("next beat did not start a full word");

    a_word_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> $past(tick_fire && last && op_reg == xlg_pkg::OP_NEXT))
        else $error("result raised without a finished word");
`endif

endmodule

`default_nettype wire
